/* rtl/core/u8nc_pkg.sv */
// Package for the UTF-8 display name checker: item types, error codes and byte constants.
package u8nc_pkg;

    // Error causes, in priority order of reporting.
    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_CONTROL = 3'd1,
        ERR_LEAD    = 3'd2,
        ERR_CONT    = 3'd3,
        ERR_TRUNC   = 3'd4,
        ERR_BLANK   = 3'd5
    } err_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       first;
        logic       last;
    } byte_item_t;

    typedef struct packed {
        logic done_res;
        logic valid_res;
        err_t error_kind;
    } result_item_t;

    localparam int unsigned OWED_W = 2;

    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_DEL   = 8'h7f;

    // Lead byte ranges.
    localparam logic [7:0] LEAD2_LO = 8'hc2;
    localparam logic [7:0] LEAD2_HI = 8'hdf;
    localparam logic [7:0] LEAD3_LO = 8'he0;
    localparam logic [7:0] LEAD3_HI = 8'hef;
    localparam logic [7:0] LEAD4_LO = 8'hf0;
    localparam logic [7:0] LEAD4_HI = 8'hf4;
    localparam logic [7:0] LEAD_SURR = 8'hed;

    // Continuation windows.
    localparam logic [7:0] CONT_LO      = 8'h80;
    localparam logic [7:0] CONT_HI      = 8'hbf;
    localparam logic [7:0] E0_CONT_LO   = 8'ha0;
    localparam logic [7:0] ED_CONT_HI   = 8'h9f;
    localparam logic [7:0] F0_CONT_LO   = 8'h90;
    localparam logic [7:0] F4_CONT_HI   = 8'h8f;

endpackage

/* rtl/core/u8nc_stream_if.sv */
// Valid/ready stream interface carrying one payload item per transfer.
interface u8nc_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/utf8_display_name_checker.sv */
// UTF-8 display name checker: strict byte-wise validation of a name, one result per byte.
//
// Usage: feed the name one byte per transfer on byte_ch, first set on its opening byte and
// last set on its closing byte. Each byte yields exactly one transfer on result_ch. Bytes
// before the last report done_res = 0, valid_res = 0 and the error latched so far. The last
// byte reports done_res = 1, valid_res = 1 for an accepted name, and the first cause of
// rejection: control character or DEL, bad lead byte (including overlong C0/C1 and F5..FF),
// bad continuation (including overlong, surrogate and above U+10FFFF forms), truncated
// sequence, or a name made only of spaces. After an error the rest of the name is ignored.
// After the last byte the state returns to reset, so a following byte opens a new name even
// without first. Throughput is one byte per clock cycle while result_ch takes results: the
// decoder state (owed continuation count, bound window, non-blank flag, latched error)
// updates when a byte leaves the input register. A byte lands in the input register at its
// input transfer; its result is then registered in the result register and offered from
// there. The result register is a full stage, so input keeps flowing while a result waits;
// a stalled result_ch stalls byte_ch only once both registers are full.
module utf8_display_name_checker (
    input  logic                clk,
    input  logic                rst_n,
    u8nc_stream_if.sink         byte_ch,
    u8nc_stream_if.source       result_ch
);

    // Input register stage
    logic                   in_valid_reg;
    u8nc_pkg::byte_item_t   in_data_reg;

    // Result register stage
    logic                   out_valid_reg;
    u8nc_pkg::result_item_t out_data_reg;

    // Decoder state
    logic [u8nc_pkg::OWED_W-1:0] owed_reg, owed_next;
    logic [7:0]                  lo_reg, lo_next;
    logic [7:0]                  hi_reg, hi_next;
    logic                        seen_reg, seen_next;
    u8nc_pkg::err_t              err_reg, err_next;

    // Checked values before the end-of-name clear
    logic [u8nc_pkg::OWED_W-1:0] owed_eff, owed_chk;
    logic [7:0]                  lo_eff, lo_chk;
    logic [7:0]                  hi_eff, hi_chk;
    logic                        seen_eff, seen_chk;
    u8nc_pkg::err_t              err_eff, err_chk;
    u8nc_pkg::err_t              verdict;
    u8nc_pkg::result_item_t      result;

    logic [7:0] b;
    logic       advance;
    logic       in_take;

    assign advance = in_valid_reg && (!out_valid_reg || result_ch.ready);
    assign byte_ch.ready = !in_valid_reg || advance;
    assign in_take = byte_ch.valid && byte_ch.ready;

    assign result_ch.valid = out_valid_reg;
    assign result_ch.data  = out_data_reg;

    assign b = in_data_reg.byte_value;

    // Byte check against the current state
    always_comb
    begin
        // first wipes the kept state before this byte is checked
        if (in_data_reg.first)
        begin
            owed_eff = '0;
            lo_eff   = u8nc_pkg::CONT_LO;
            hi_eff   = u8nc_pkg::CONT_HI;
            seen_eff = 1'b0;
            err_eff  = u8nc_pkg::ERR_NONE;
        end
        else
        begin
            owed_eff = owed_reg;
            lo_eff   = lo_reg;
            hi_eff   = hi_reg;
            seen_eff = seen_reg;
            err_eff  = err_reg;
        end

        owed_chk = owed_eff;
        lo_chk   = lo_eff;
        hi_chk   = hi_eff;
        seen_chk = seen_eff;
        err_chk  = err_eff;

        if (err_eff == u8nc_pkg::ERR_NONE)
        begin
            if (owed_eff != '0)
            begin
                // continuation expected
                if (b < lo_eff || b > hi_eff)
                begin
                    err_chk = u8nc_pkg::ERR_CONT;
                end
                else
                begin
                    owed_chk = owed_eff - 2'd1;
                    lo_chk   = u8nc_pkg::CONT_LO;
                    hi_chk   = u8nc_pkg::CONT_HI;
                end
            end
            else if (!b[7])
            begin
                if (b < u8nc_pkg::ASCII_SPACE || b == u8nc_pkg::ASCII_DEL)
                begin
                    err_chk = u8nc_pkg::ERR_CONTROL;
                end
                else if (b != u8nc_pkg::ASCII_SPACE)
                begin
                    seen_chk = 1'b1;
                end
            end
            else
            begin
                // lead byte position
                seen_chk = 1'b1;
                lo_chk   = u8nc_pkg::CONT_LO;
                hi_chk   = u8nc_pkg::CONT_HI;
                if (b >= u8nc_pkg::LEAD2_LO && b <= u8nc_pkg::LEAD2_HI)
                begin
                    owed_chk = 2'd1;
                end
                else if (b >= u8nc_pkg::LEAD3_LO && b <= u8nc_pkg::LEAD3_HI)
                begin
                    owed_chk = 2'd2;
                    if (b == u8nc_pkg::LEAD3_LO)
                    begin
                        lo_chk = u8nc_pkg::E0_CONT_LO;     // no overlong 3-byte forms
                    end
                    if (b == u8nc_pkg::LEAD_SURR)
                    begin
                        hi_chk = u8nc_pkg::ED_CONT_HI;     // no surrogates
                    end
                end
                else if (b >= u8nc_pkg::LEAD4_LO && b <= u8nc_pkg::LEAD4_HI)
                begin
                    owed_chk = 2'd3;
                    if (b == u8nc_pkg::LEAD4_LO)
                    begin
                        lo_chk = u8nc_pkg::F0_CONT_LO;     // no overlong 4-byte forms
                    end
                    if (b == u8nc_pkg::LEAD4_HI)
                    begin
                        hi_chk = u8nc_pkg::F4_CONT_HI;     // cap at U+10FFFF
                    end
                end
                else
                begin
                    err_chk = u8nc_pkg::ERR_LEAD;
                end
            end
        end

        // verdict priority: latched error, then truncation, then blank
        verdict = err_chk;
        if (verdict == u8nc_pkg::ERR_NONE && owed_chk != '0)
        begin
            verdict = u8nc_pkg::ERR_TRUNC;
        end
        if (verdict == u8nc_pkg::ERR_NONE && !seen_chk)
        begin
            verdict = u8nc_pkg::ERR_BLANK;
        end

        result.done_res   = in_data_reg.last;
        result.valid_res  = in_data_reg.last && (verdict == u8nc_pkg::ERR_NONE);
        result.error_kind = in_data_reg.last ? verdict : err_chk;

        // end of name returns the state to reset values
        if (in_data_reg.last)
        begin
            owed_next = '0;
            lo_next   = u8nc_pkg::CONT_LO;
            hi_next   = u8nc_pkg::CONT_HI;
            seen_next = 1'b0;
            err_next  = u8nc_pkg::ERR_NONE;
        end
        else
        begin
            owed_next = owed_chk;
            lo_next   = lo_chk;
            hi_next   = hi_chk;
            seen_next = seen_chk;
            err_next  = err_chk;
        end
    end

    // Control and decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            owed_reg      <= '0;
            lo_reg        <= u8nc_pkg::CONT_LO;
            hi_reg        <= u8nc_pkg::CONT_HI;
            seen_reg      <= 1'b0;
            err_reg       <= u8nc_pkg::ERR_NONE;
        end
        else
        begin
            if (byte_ch.ready)
            begin
                in_valid_reg <= byte_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                owed_reg      <= owed_next;
                lo_reg        <= lo_next;
                hi_reg        <= hi_next;
                seen_reg      <= seen_next;
                err_reg       <= err_next;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= byte_ch.data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    // Assertions
    a_accept_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.valid_res |->
            out_data_reg.done_res && out_data_reg.error_kind == u8nc_pkg::ERR_NONE)
        else $error("accept reported without final verdict or with an error cause");

    a_partial_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.done_res |->
            out_data_reg.error_kind != u8nc_pkg::ERR_TRUNC &&
            out_data_reg.error_kind != u8nc_pkg::ERR_BLANK)
        else $error("end-of-name cause reported before the last byte");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_data_reg.last |=>
            owed_reg == '0 && err_reg == u8nc_pkg::ERR_NONE && !seen_reg)
        else $error("decoder state not cleared after the last byte");

    a_bounds_window: assert property (@(posedge clk) disable iff (!rst_n)
        lo_reg[7] && hi_reg[7] && lo_reg <= hi_reg)
        else $error("continuation window outside 80..BF");

    a_result_follows_byte: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("checked byte produced no result");

endmodule
